// ----- sv/afpp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afpp_pkg
// Shared types and codes for the packet parser block.
// ----------------------------------------------------------------------------
package afpp_pkg;

  localparam int ADDR_W = 21;
  localparam int CNT_W  = 14;
  localparam int SHADOW_DEPTH_DEFAULT = 128;

  // bus operation codes
  localparam logic [1:0] OP_INDEX = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // the latched index that routes block-site data writes to the parser
  localparam logic [7:0] PARSER_INDEX = 8'd1;

  // event codes
  localparam logic [2:0] EV_NONE         = 3'd0;
  localparam logic [2:0] EV_IMMEDIATE    = 3'd1;
  localparam logic [2:0] EV_REG_PACKET   = 3'd2;
  localparam logic [2:0] EV_VOICE_PACKET = 3'd3;
  localparam logic [2:0] EV_REG_WRITE    = 3'd4;
  localparam logic [2:0] EV_VOICE_WRITE  = 3'd5;

  typedef struct packed {
    logic [1:0]        operation;
    logic [7:0]        write_value;
    logic              fifo_sel;
    logic [ADDR_W-1:0] read_address;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [2:0]        event_kind;
    logic [7:0]        event_index;
    logic [7:0]        event_value;
    logic [ADDR_W-1:0] event_delay;
    logic [ADDR_W-1:0] event_address;
    logic [CNT_W-1:0]  event_count;
    logic              terminal;
    logic [6:0]        read_data;
  } rsp_t;

  // shadow store write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [6:0]        data;
  } shadow_wr_t;

endpackage

// ----- sv/afpp_shadow.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afpp_shadow
// Shadow register store: one write port, one registered read port, per-entry
// valid bits cleared at reset, bypass of a write landing on the same edge.
// ----------------------------------------------------------------------------
module afpp_shadow #(
  parameter int SHADOW_DEPTH = afpp_pkg::SHADOW_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [afpp_pkg::ADDR_W-1:0] rd_addr,
  input  afpp_pkg::shadow_wr_t       wr,
  output logic [6:0]                 rd_data
);
  import afpp_pkg::*;

  localparam int AW = (SHADOW_DEPTH > 1) ? $clog2(SHADOW_DEPTH) : 1;

  logic [6:0]              mem [SHADOW_DEPTH];
  logic [SHADOW_DEPTH-1:0] valid;
  logic [6:0]              rd_q;
  logic                    rd_vld_q;
  logic                    byp_q;
  logic [6:0]              byp_data_q;

  logic [AW-1:0] widx;
  logic [AW-1:0] ridx;

  assign widx = wr.addr[AW-1:0];
  assign ridx = rd_addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[widx] <= wr.data;
    end
    if (rd_en) begin
      rd_q       <= mem[ridx];
      byp_data_q <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_vld_q <= 1'b0;
      byp_q    <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[widx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= valid[ridx];
        byp_q    <= wr.en && (wr.addr == rd_addr);
      end
    end
  end

  // never-written entries read as zero
  assign rd_data = byp_q ? byp_data_q : (rd_vld_q ? rd_q : 7'd0);

endmodule

// ----- sv/afpp_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afpp_parser
// Index latch and varint packet parser; forms one result per bus access.
// ----------------------------------------------------------------------------
module afpp_parser #(
  parameter int SHADOW_DEPTH = afpp_pkg::SHADOW_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  afpp_pkg::req_t       req,
  input  logic [6:0]           rd_data,
  output afpp_pkg::rsp_t       res,
  output afpp_pkg::shadow_wr_t wr
);
  import afpp_pkg::*;

  localparam logic [3:0] ST_DELAY0     = 4'd0;
  localparam logic [3:0] ST_DELAY1     = 4'd1;
  localparam logic [3:0] ST_DELAY2     = 4'd2;
  localparam logic [3:0] ST_ADDR0      = 4'd3;
  localparam logic [3:0] ST_ADDR1      = 4'd4;
  localparam logic [3:0] ST_ADDR2      = 4'd5;
  localparam logic [3:0] ST_COUNT0     = 4'd6;
  localparam logic [3:0] ST_COUNT1     = 4'd7;
  localparam logic [3:0] ST_REG_DATA   = 4'd9;
  localparam logic [3:0] ST_VOICE_DATA = 4'd11;

  localparam logic [ADDR_W-1:0] DEPTH_LIMIT = ADDR_W'(SHADOW_DEPTH);

  logic [7:0]        latched_index, latched_index_next;
  logic [3:0]        parse_state, parse_state_next;
  logic [ADDR_W-1:0] delay_accum, delay_accum_next;
  logic [ADDR_W-1:0] address_accum, address_accum_next;
  logic [CNT_W-1:0]  bytes_remaining, bytes_remaining_next;

  logic [6:0]        pay;
  logic              last;
  logic [ADDR_W-1:0] addr_mid;
  logic [CNT_W-1:0]  cnt_hi;
  logic [CNT_W-1:0]  cnt_dec;
  logic              wr_hit;

  assign pay      = req.write_value[6:0];
  assign last     = req.write_value[7];
  assign addr_mid = address_accum | {7'd0, pay, 7'd0};
  assign cnt_hi   = bytes_remaining | {pay, 7'd0};
  assign cnt_dec  = bytes_remaining - CNT_W'(1);

  always_comb begin
    latched_index_next   = latched_index;
    parse_state_next     = parse_state;
    delay_accum_next     = delay_accum;
    address_accum_next   = address_accum;
    bytes_remaining_next = bytes_remaining;
    res    = '0;
    res.ok = 1'b1;
    wr_hit = 1'b0;

    unique case (req.operation)
      OP_INDEX: begin
        latched_index_next = req.write_value;
      end
      OP_DATA: begin
        res.event_index = latched_index;
        res.event_value = req.write_value;
        if (!req.fifo_sel || latched_index != PARSER_INDEX) begin
          res.event_kind = EV_IMMEDIATE;
        end else begin
          unique case (parse_state)
            ST_DELAY1: begin
              delay_accum_next = delay_accum | {7'd0, pay, 7'd0};
              parse_state_next = last ? ST_ADDR0 : ST_DELAY2;
            end
            ST_DELAY2: begin
              delay_accum_next = delay_accum | {pay, 14'd0};
              parse_state_next = ST_ADDR0;
            end
            ST_ADDR0: begin
              address_accum_next = {14'd0, pay};
              if (last) begin
                // short address: register packet opens now
                parse_state_next  = ST_REG_DATA;
                res.event_kind    = EV_REG_PACKET;
                res.event_delay   = delay_accum;
                res.event_address = {14'd0, pay};
              end else begin
                parse_state_next = ST_ADDR1;
              end
            end
            ST_ADDR1: begin
              address_accum_next = addr_mid;
              if (last) begin
                parse_state_next  = ST_REG_DATA;
                res.event_kind    = EV_REG_PACKET;
                res.event_delay   = delay_accum;
                res.event_address = addr_mid;
              end else begin
                parse_state_next = ST_ADDR2;
              end
            end
            ST_ADDR2: begin
              address_accum_next = address_accum | {pay, 14'd0};
              parse_state_next   = ST_COUNT0;
            end
            ST_COUNT0: begin
              bytes_remaining_next = {7'd0, pay};
              if (!last) begin
                parse_state_next = ST_COUNT1;
              end else if (pay != 7'd0) begin
                parse_state_next  = ST_VOICE_DATA;
                res.event_kind    = EV_VOICE_PACKET;
                res.event_delay   = delay_accum;
                res.event_address = address_accum;
                res.event_count   = {7'd0, pay};
              end else begin
                parse_state_next = ST_DELAY0;
              end
            end
            ST_COUNT1: begin
              bytes_remaining_next = cnt_hi;
              if (cnt_hi != '0) begin
                parse_state_next  = ST_VOICE_DATA;
                res.event_kind    = EV_VOICE_PACKET;
                res.event_delay   = delay_accum;
                res.event_address = address_accum;
                res.event_count   = cnt_hi;
              end else begin
                parse_state_next = ST_DELAY0;
              end
            end
            ST_REG_DATA: begin
              res.event_kind     = EV_REG_WRITE;
              res.event_address  = address_accum;
              res.event_value    = {1'b0, pay};
              res.terminal       = last;
              wr_hit             = address_accum < DEPTH_LIMIT;
              address_accum_next = address_accum + ADDR_W'(1);
              if (last) begin
                parse_state_next = ST_DELAY0;
              end
            end
            ST_VOICE_DATA: begin
              res.event_kind       = EV_VOICE_WRITE;
              res.event_address    = address_accum;
              bytes_remaining_next = cnt_dec;
              if (cnt_dec != '0) begin
                address_accum_next = address_accum + ADDR_W'(1);
              end else begin
                parse_state_next = ST_DELAY0;
              end
            end
            default: begin
              // first delay byte, also any unused code
              delay_accum_next = {14'd0, pay};
              parse_state_next = last ? ST_ADDR0 : ST_DELAY1;
            end
          endcase
        end
      end
      OP_READ: begin
        if (req.read_address < DEPTH_LIMIT) begin
          res.read_data = rd_data;
        end else begin
          res.ok = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign wr.en   = step && wr_hit;
  assign wr.addr = address_accum;
  assign wr.data = pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      latched_index   <= '0;
      parse_state     <= ST_DELAY0;
      delay_accum     <= '0;
      address_accum   <= '0;
      bytes_remaining <= '0;
    end else if (step) begin
      latched_index   <= latched_index_next;
      parse_state     <= parse_state_next;
      delay_accum     <= delay_accum_next;
      address_accum   <= address_accum_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule

// ----- sv/audio_fifo_packet_parser_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_fifo_packet_parser_top
// Register-bus access parser: index latch, varint packet decode, shadow store.
// ----------------------------------------------------------------------------
//
//   channel | ports                       | beat
//   --------+-----------------------------+--------------------------------
//   req     | req_valid, req_ready, req   | one bus access (req_t)
//   rsp     | rsp_valid, rsp_ready, rsp   | one result per access (rsp_t)
//
// one beat per cycle sustained while rsp_ready stays high; each access passes
// through the input stage and then sits in the result register
// the shadow store read is issued as the access enters the input stage, so
// the single memory read port sets the one-access-per-cycle figure
// reset clears the parser state and the shadow valid bits at once; there is
// no clearing pass, the block takes beats on the first cycle after reset
// a stalled rsp holds the result register; the input stage keeps taking a
// beat as long as the result register can drain
//
module audio_fifo_packet_parser_top #(
  parameter int SHADOW_DEPTH = afpp_pkg::SHADOW_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  afpp_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output afpp_pkg::rsp_t   rsp
);
  import afpp_pkg::*;

  // input stage
  logic       s1_valid;
  req_t       s1;
  // result stage
  rsp_t       res;
  shadow_wr_t wr;
  logic [6:0] rd_data;

  logic out_free;
  logic step;
  logic req_fire;

  // result register free when empty or draining this cycle
  assign out_free  = !rsp_valid || rsp_ready;
  // the input stage advances into the result register
  assign step      = s1_valid && out_free;
  assign req_ready = !s1_valid || out_free;
  assign req_fire  = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_ready) begin
        s1_valid <= req_valid;
      end
      if (out_free) begin
        rsp_valid <= s1_valid;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1 <= req;
    end
    if (step) begin
      rsp <= res;
    end
  end

  // shadow store, read as the beat enters the input stage; a write from the
  // beat leaving the input stage on the same edge is bypassed
  afpp_shadow #(
    .SHADOW_DEPTH(SHADOW_DEPTH)
  ) u_shadow (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (req_fire),
    .rd_addr (req.read_address),
    .wr      (wr),
    .rd_data (rd_data)
  );

  // index latch and packet parser, state moves only when a beat advances
  afpp_parser #(
    .SHADOW_DEPTH(SHADOW_DEPTH)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .req     (s1),
    .rd_data (rd_data),
    .res     (res),
    .wr      (wr)
  );

  // an accepted beat always lands in the input stage
  a_fire_fills: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> s1_valid)
    else $error("accepted beat did not reach input stage");

  // an empty input stage never refuses a beat
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> req_ready)
    else $error("input stage empty but not ready");

  // only shadow reads may clear ok
  a_ok_only_read: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !res.ok |-> s1.operation == OP_READ)
    else $error("ok cleared on a non-read access");

  // events come only from data writes
  a_event_data: assert property (@(posedge clk) disable iff (rst)
    s1_valid && res.event_kind != EV_NONE |-> s1.operation == OP_DATA)
    else $error("event raised by a non-data access");

  // shadow writes happen only on a parser register write
  a_write_kind: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> step && res.event_kind == EV_REG_WRITE)
    else $error("shadow write outside a register write");

endmodule
